>>> rtl/ptc_pkg.sv
`default_nettype none
package ptc_pkg;

	localparam int OUT_FRAC_BITS = 16;
	localparam int Q             = 24;
	localparam int DIV_W         = 24;
	localparam int NUM_W         = 64;
	localparam int PC_W          = 5;
	localparam int REG_IDX_W     = 3;
	localparam int HI_SHIFT      = 32 - Q;

	localparam logic [DIV_W-1:0] DOUT_TEMP  = DIV_W'(1 << (Q - OUT_FRAC_BITS));
	localparam logic [DIV_W-1:0] DOUT_PRESS = DIV_W'(100 << (Q - OUT_FRAC_BITS));

	localparam logic [PC_W-1:0] PC_PRESS = PC_W'(0);
	localparam logic [PC_W-1:0] PC_TEMP  = PC_W'(25);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_COEF_LOW   = 3'd0,
		REG_COEF_MID   = 3'd1,
		REG_COEF_HIGH  = 3'd2,
		REG_TEMP_OSR   = 3'd3,
		REG_PRESS_OSR  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_DIV_SCALE,
		OP_STORE,
		OP_MUL_C,
		OP_ADD_C,
		OP_MQ_PREP,
		OP_MQ_LO,
		OP_MQ_HI,
		OP_MQ_SUM,
		OP_MQ_ADD,
		OP_SAVE_A,
		OP_DIV_OUT,
		OP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		CS_C0H,
		CS_C1,
		CS_C00,
		CS_C10,
		CS_C01,
		CS_C11,
		CS_C20,
		CS_C21,
		CS_C30,
		CS_ACC_A
	} coef_sel_t;

	typedef enum logic {
		BV_X,
		BV_T
	} bvar_t;

	typedef struct packed {
		dp_op_t    op;
		coef_sel_t coef;
		bvar_t     bvar;
		logic      last;
	} uinstr_t;

	typedef struct packed {
		logic      load;
		dp_op_t    op;
		coef_sel_t coef;
		bvar_t     bvar;
	} dp_cmd_t;

	typedef struct packed {
		logic func;
		logic div_busy;
		logic out_busy;
	} dp_stat_t;

	function automatic logic [DIV_W-1:0] scale_factor(input logic [2:0] code);
		logic [DIV_W-1:0] s;
		case (code)
			3'd0: s = DIV_W'(524288);
			3'd1: s = DIV_W'(1572864);
			3'd2: s = DIV_W'(3670016);
			3'd3: s = DIV_W'(7864320);
			3'd4: s = DIV_W'(253952);
			3'd5: s = DIV_W'(516096);
			3'd6: s = DIV_W'(1040384);
			default: s = DIV_W'(2088960);
		endcase
		return s;
	endfunction

	// pressure program from PC_PRESS, temperature program from PC_TEMP
	function automatic uinstr_t ucode(input logic [PC_W-1:0] pc);
		uinstr_t u;
		case (pc)
			5'd0:  u = '{OP_MUL_C,   CS_C30,   BV_X, 1'b0};
			5'd1:  u = '{OP_ADD_C,   CS_C20,   BV_X, 1'b0};
			5'd2:  u = '{OP_MQ_PREP, CS_C0H,   BV_X, 1'b0};
			5'd3:  u = '{OP_MQ_LO,   CS_C0H,   BV_X, 1'b0};
			5'd4:  u = '{OP_MQ_HI,   CS_C0H,   BV_X, 1'b0};
			5'd5:  u = '{OP_MQ_SUM,  CS_C0H,   BV_X, 1'b0};
			5'd6:  u = '{OP_MQ_ADD,  CS_C10,   BV_X, 1'b0};
			5'd7:  u = '{OP_MQ_PREP, CS_C0H,   BV_X, 1'b0};
			5'd8:  u = '{OP_MQ_LO,   CS_C0H,   BV_X, 1'b0};
			5'd9:  u = '{OP_MQ_HI,   CS_C0H,   BV_X, 1'b0};
			5'd10: u = '{OP_MQ_SUM,  CS_C0H,   BV_X, 1'b0};
			5'd11: u = '{OP_MQ_ADD,  CS_C00,   BV_X, 1'b0};
			5'd12: u = '{OP_SAVE_A,  CS_C0H,   BV_X, 1'b0};
			5'd13: u = '{OP_MUL_C,   CS_C21,   BV_X, 1'b0};
			5'd14: u = '{OP_ADD_C,   CS_C11,   BV_X, 1'b0};
			5'd15: u = '{OP_MQ_PREP, CS_C0H,   BV_X, 1'b0};
			5'd16: u = '{OP_MQ_LO,   CS_C0H,   BV_X, 1'b0};
			5'd17: u = '{OP_MQ_HI,   CS_C0H,   BV_X, 1'b0};
			5'd18: u = '{OP_MQ_SUM,  CS_C0H,   BV_X, 1'b0};
			5'd19: u = '{OP_MQ_ADD,  CS_C01,   BV_X, 1'b0};
			5'd20: u = '{OP_MQ_PREP, CS_C0H,   BV_T, 1'b0};
			5'd21: u = '{OP_MQ_LO,   CS_C0H,   BV_T, 1'b0};
			5'd22: u = '{OP_MQ_HI,   CS_C0H,   BV_T, 1'b0};
			5'd23: u = '{OP_MQ_SUM,  CS_C0H,   BV_T, 1'b0};
			5'd24: u = '{OP_MQ_ADD,  CS_ACC_A, BV_T, 1'b1};
			5'd25: u = '{OP_MUL_C,   CS_C1,    BV_X, 1'b0};
			5'd26: u = '{OP_ADD_C,   CS_C0H,   BV_X, 1'b1};
			default: u = '{OP_NOP,   CS_C0H,   BV_X, 1'b1};
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

>>> rtl/ptc_div.sv
`default_nettype none
module ptc_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ptc_pkg::NUM_W-1:0] dividend,
	input  wire logic [ptc_pkg::DIV_W-1:0] divisor,
	output logic                           busy,
	output logic [ptc_pkg::NUM_W-1:0]      quotient
);
	import ptc_pkg::*;

	localparam int BITS_PER_CYCLE = 2;
	localparam int STEPS          = NUM_W / BITS_PER_CYCLE;
	localparam int CNT_W          = $clog2(STEPS);

	logic [NUM_W-1:0] num_q, num_nx;
	logic [DIV_W:0]   rem_q, rem_nx;
	logic [DIV_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	always_comb begin
		logic [DIV_W:0]   r;
		logic [NUM_W-1:0] n;
		r = rem_q;
		n = num_q;
		for (int k = 0; k < BITS_PER_CYCLE; k++) begin
			r = {r[DIV_W-1:0], n[NUM_W-1]};
			n = {n[NUM_W-2:0], 1'b0};
			if (r >= {1'b0, den_q}) begin
				r    = r - {1'b0, den_q};
				n[0] = 1'b1;
			end
		end
		rem_nx = r;
		num_nx = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
	end

	assign busy     = busy_q;
	assign quotient = num_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && cnt_q == '0))
		else $error("divider did not start");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == CNT_W'(STEPS - 1) && !start) |=> !busy_q)
		else $error("divider ran past its last step");

endmodule
`default_nettype wire

>>> rtl/ptc_ctrl.sv
`default_nettype none
module ptc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ptc_pkg::dp_stat_t stat,
	output ptc_pkg::dp_cmd_t       cmd
);
	import ptc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE       = 6'b000001,
		S_SCALE      = 6'b000010,
		S_SCALE_WAIT = 6'b000100,
		S_RUN        = 6'b001000,
		S_OUT_START  = 6'b010000,
		S_OUT_WAIT   = 6'b100000
	} state_t;

	state_t          state_q, state_d;
	logic [PC_W-1:0] pc_q, pc_d;
	uinstr_t         ui;

	assign ui = ucode(pc_q);

	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		in_ready = 1'b0;
		cmd      = '{load: 1'b0, op: OP_NOP, coef: CS_C0H, bvar: BV_X};
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCALE;
				end
			end
			S_SCALE: begin
				cmd.op  = OP_DIV_SCALE;
				state_d = S_SCALE_WAIT;
			end
			S_SCALE_WAIT: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_STORE;
					pc_d    = stat.func ? PC_PRESS : PC_TEMP;
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				cmd.op   = ui.op;
				cmd.coef = ui.coef;
				cmd.bvar = ui.bvar;
				if (ui.last) begin
					state_d = S_OUT_START;
				end else begin
					pc_d = pc_q + PC_W'(1);
				end
			end
			S_OUT_START: begin
				cmd.op  = OP_DIV_OUT;
				state_d = S_OUT_WAIT;
			end
			S_OUT_WAIT: begin
				// hold while the divider is still busy or the previous result is still unsent
				if (!stat.div_busy && !stat.out_busy) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/ptc_datapath.sv
`default_nettype none
module ptc_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ptc_pkg::dp_cmd_t              cmd,
	output ptc_pkg::dp_stat_t                  stat,
	input  wire logic                          cfg_valid,
	input  wire logic [ptc_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data,
	input  wire logic                          in_func,
	input  wire logic signed [23:0]            in_raw,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               out_quantity,
	output logic signed [31:0]                 out_value
);
	import ptc_pkg::*;

	localparam logic [64:0] RND_HALF = 65'(1) << (Q - 1);

	logic [63:0] coef_low_q, coef_mid_q;
	logic [15:0] coef_high_q;
	logic [2:0]  tosr_q, posr_q;

	logic               func_q;
	logic signed [23:0] raw_q;
	logic signed [31:0] x_q, t_q;
	logic signed [63:0] acc_q, a_q;
	logic [63:0]        mag_q, prod_q, r_q;
	logic               ms_q, cs_q, neg_q;
	logic               out_valid_q, out_quantity_q;
	logic [31:0]        out_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_low_q  <= '0;
			coef_mid_q  <= '0;
			coef_high_q <= '0;
			tosr_q      <= 3'd3;
			posr_q      <= 3'd3;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_COEF_LOW:  coef_low_q  <= cfg_data;
				REG_COEF_MID:  coef_mid_q  <= cfg_data;
				REG_COEF_HIGH: coef_high_q <= cfg_data[15:0];
				REG_TEMP_OSR:  tosr_q      <= cfg_data[2:0];
				REG_PRESS_OSR: posr_q      <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	logic signed [11:0] c0, c0_adj, c0h, c1;
	logic signed [19:0] c00, c10;
	logic signed [15:0] c01, c11, c20, c21, c30;

	assign c0  = coef_low_q[63:52];
	assign c1  = coef_low_q[51:40];
	assign c00 = coef_low_q[39:20];
	assign c10 = coef_low_q[19:0];
	assign c01 = coef_mid_q[63:48];
	assign c11 = coef_mid_q[47:32];
	assign c20 = coef_mid_q[31:16];
	assign c21 = coef_mid_q[15:0];
	assign c30 = coef_high_q;

	// halve towards zero
	assign c0_adj = c0 + 12'(c0[11]);
	assign c0h    = c0_adj >>> 1;

	logic signed [19:0] coef_s;
	logic [19:0]        coef_mag;
	logic signed [63:0] base_s;

	always_comb begin
		case (cmd.coef)
			CS_C0H:  coef_s = 20'(c0h);
			CS_C1:   coef_s = 20'(c1);
			CS_C00:  coef_s = c00;
			CS_C10:  coef_s = c10;
			CS_C01:  coef_s = 20'(c01);
			CS_C11:  coef_s = 20'(c11);
			CS_C20:  coef_s = 20'(c20);
			CS_C21:  coef_s = 20'(c21);
			CS_C30:  coef_s = 20'(c30);
			default: coef_s = '0;
		endcase
	end

	assign coef_mag = coef_s[19] ? 20'(-coef_s) : coef_s;
	assign base_s   = (cmd.coef == CS_ACC_A) ? a_q : (64'(coef_s) <<< Q);

	logic signed [31:0] bvar_s;
	logic [31:0]        bvar_mag, x_mag;

	assign bvar_s   = (cmd.bvar == BV_T) ? t_q : x_q;
	assign bvar_mag = bvar_s[31] ? 32'(-bvar_s) : bvar_s;
	assign x_mag    = x_q[31] ? 32'(-x_q) : x_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	always_comb begin
		case (cmd.op)
			OP_MUL_C: begin
				mul_a = 32'(coef_mag);
				mul_b = x_mag;
			end
			OP_MQ_HI: begin
				mul_a = mag_q[63:32];
				mul_b = bvar_mag;
			end
			default: begin
				mul_a = mag_q[31:0];
				mul_b = bvar_mag;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	logic signed [63:0] prod_s, r_s;
	logic [64:0]        lo_rnd;
	logic [63:0]        acc_mag;

	assign prod_s  = cs_q ? -$signed(prod_q) : $signed(prod_q);
	assign r_s     = ms_q ? -$signed(r_q) : $signed(r_q);
	assign lo_rnd  = {1'b0, prod_q} + RND_HALF;
	assign acc_mag = acc_q[63] ? 64'(-acc_q) : acc_q;

	logic             div_start, div_busy;
	logic [DIV_W-1:0] scale, dout, div_den;
	logic [NUM_W-1:0] div_num, div_quot;
	logic [23:0]      raw_mag;

	assign scale     = scale_factor(func_q ? posr_q : tosr_q);
	assign dout      = func_q ? DOUT_PRESS : DOUT_TEMP;
	assign raw_mag   = raw_q[23] ? 24'(-raw_q) : raw_q;
	assign div_start = (cmd.op == OP_DIV_SCALE) || (cmd.op == OP_DIV_OUT);
	assign div_den   = (cmd.op == OP_DIV_SCALE) ? scale : dout;
	assign div_num   = (cmd.op == OP_DIV_SCALE)
		? ((NUM_W'(raw_mag) << Q) + NUM_W'(scale >> 1))
		: (acc_mag + NUM_W'(dout >> 1));

	ptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	logic [31:0] q_signed, sat_v;

	assign q_signed = neg_q ? (~div_quot[31:0] + 32'd1) : div_quot[31:0];

	always_comb begin
		if (!neg_q) begin
			sat_v = (div_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quot[31:0];
		end else begin
			sat_v = (div_quot > 64'h8000_0000) ? 32'h8000_0000 : q_signed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((cmd.op == OP_STORE) && !func_q) begin
				t_q <= q_signed;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			raw_q  <= in_raw;
		end
		if ((cmd.op == OP_MUL_C) || (cmd.op == OP_MQ_LO) || (cmd.op == OP_MQ_HI)) begin
			prod_q <= mul_p;
		end
		case (cmd.op)
			OP_DIV_SCALE: neg_q <= raw_q[23];
			OP_DIV_OUT:   neg_q <= acc_q[63];
			OP_STORE:     x_q   <= q_signed;
			OP_MUL_C:     cs_q  <= x_q[31] ^ coef_s[19];
			OP_ADD_C:     acc_q <= base_s + prod_s;
			OP_MQ_PREP: begin
				mag_q <= acc_mag;
				ms_q  <= acc_q[63] ^ bvar_s[31];
			end
			OP_MQ_HI:     r_q   <= 64'(lo_rnd >> Q);
			OP_MQ_SUM:    r_q   <= r_q + (prod_q << HI_SHIFT);
			OP_MQ_ADD:    acc_q <= base_s + r_s;
			OP_SAVE_A:    a_q   <= acc_q;
			OP_OUT: begin
				out_value_q    <= sat_v;
				out_quantity_q <= func_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.func     = func_q;
	assign stat.div_busy = div_busy;
	assign stat.out_busy = out_valid_q & ~out_ready;

	assign out_valid    = out_valid_q;
	assign out_quantity = out_quantity_q;
	assign out_value    = out_value_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> !(out_valid_q && !out_ready))
		else $error("result overwritten before it was taken");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == OP_DIV_SCALE) || (cmd.op == OP_DIV_OUT)) |-> !div_busy)
		else $error("divider restarted while busy");

	a_quot_ready: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == OP_STORE) || (cmd.op == OP_OUT)) |-> !div_busy)
		else $error("quotient taken before the divider finished");

endmodule
`default_nettype wire

>>> rtl/pressure_temperature_compensation.sv
// Barometric sensor compensation.
// Input beats on s_*: tuser[0] selects temperature (0) or pressure (1), tdata
// holds the signed 24-bit raw reading. Each beat gives one output beat on m_*:
// tuser[0] echoes the selector, tdata is the saturated signed Q16.16 result.
// A temperature beat also updates the stored scaled temperature used by
// later pressure beats; pressure before any temperature uses zero.
// The cfg_* channel writes the three calibration registers and the two
// oversampling codes by index; it is always ready and must only be used idle.
// Two passes through the shared radix-4 divider (for the oversampling
// scaling and the final output scaling) and the sequence of 32x32 products
// on the single multiplier make up each computation; one item is computed
// at a time, so a new input beat is taken only once the previous result
// has been passed to the output register.
// Reset clears the calibration registers, sets both oversampling codes to 3
// and zeroes the stored temperature. A stalled receiver holds the result in
// the output register; the next input beat is taken meanwhile and its result
// waits until the previous one has gone.
`default_nettype none
module pressure_temperature_compensation (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [23:0]                   s_tdata,  // raw_sample
	input  wire logic [0:0]                    s_tuser,  // func
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [31:0]                        m_tdata,  // compensated_value
	output logic [0:0]                         m_tuser,  // quantity
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ptc_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data
);
	import ptc_pkg::*;

	dp_cmd_t            cmd;
	dp_stat_t           stat;
	logic signed [31:0] out_value;

	assign cfg_ready = 1'b1;

	ptc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_func      (s_tuser[0]),
		.in_raw       ($signed(s_tdata)),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_quantity (m_tuser[0]),
		.out_value    (out_value)
	);

	assign m_tdata = out_value;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
module tb_top;
	import ptc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 123;
	localparam int MAX_WAIT = 11;
	localparam logic FUNC_TEMP = 1'b0;
	localparam logic FUNC_PRESS = 1'b1;
	localparam longint Q_ONE = 64'sd1 << Q;
	localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

	typedef struct packed {
		logic        quantity;
		logic [31:0] value;
	} reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata = '0;
	logic [0:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;
	logic [0:0]           m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;

	// calibration and scaled temperature as the block should hold them
	logic [63:0] coef_low;
	logic [63:0] coef_mid;
	logic [15:0] coef_high;
	logic [2:0]  temp_code;
	logic [2:0]  press_code;
	int          stored_temp;

	reading_t expected_readings[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	bit       src_quiet = 1'b0;
	bit       sink_quiet = 1'b0;

	pressure_temperature_compensation i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] osr_divisor(logic [2:0] code);
		logic [63:0] d;
		case (code)
			3'd0: d = 64'd524288;
			3'd1: d = 64'd1572864;
			3'd2: d = 64'd3670016;
			3'd3: d = 64'd7864320;
			3'd4: d = 64'd253952;
			3'd5: d = 64'd516096;
			3'd6: d = 64'd1040384;
			default: d = 64'd2088960;
		endcase
		return d;
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		logic [63:0] u;
		u = v;
		return (v < 0) ? -u : u;
	endfunction

	function automatic longint signed_clamp(logic [63:0] m, bit neg);
		logic [63:0] c;
		c = (m > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
		return neg ? -longint'(c) : longint'(c);
	endfunction

	// round(a * b / 2^24), ties away from zero, unsigned wrap as in 64-bit hardware
	function automatic longint mul_q24(longint a, longint b);
		logic [63:0] ma, mb, hi, lo, r;
		ma = magnitude(a);
		mb = magnitude(b) & 64'hFFFF_FFFF;
		hi = (ma >> 32) * mb;
		lo = (ma & 64'hFFFF_FFFF) * mb;
		r = (hi << (32 - Q)) + ((lo + (64'd1 << (Q - 1))) >> Q);
		return signed_clamp(r, (a < 0) != (b < 0));
	endfunction

	function automatic longint div_round(longint v, logic [63:0] d);
		logic [63:0] m;
		m = magnitude(v);
		return signed_clamp((m + d / 2) / d, v < 0);
	endfunction

	function automatic logic [31:0] to_q16(longint q24, logic [63:0] extra);
		longint r;
		r = div_round(q24, extra << (Q - OUT_FRAC_BITS));
		if (r > SAT_HI)
			r = SAT_HI;
		if (r < SAT_LO)
			r = SAT_LO;
		return r[31:0];
	endfunction

	function automatic reading_t compensate(logic func, logic [23:0] raw_bits);
		longint raw, c0, c1, c00, c10, c01, c11, c20, c21, c30;
		longint scaled, t, a, b;
		reading_t r;
		raw = $signed(raw_bits);
		c0 = $signed(coef_low[63:52]);
		c1 = $signed(coef_low[51:40]);
		c00 = $signed(coef_low[39:20]);
		c10 = $signed(coef_low[19:0]);
		c01 = $signed(coef_mid[63:48]);
		c11 = $signed(coef_mid[47:32]);
		c20 = $signed(coef_mid[31:16]);
		c21 = $signed(coef_mid[15:0]);
		c30 = $signed(coef_high);
		r.quantity = func;
		if (func == FUNC_TEMP) begin
			scaled = div_round(raw * Q_ONE, osr_divisor(temp_code));
			stored_temp = scaled[31:0];
			r.value = to_q16((c0 / 2) * Q_ONE + c1 * scaled, 64'd1);
		end else begin
			scaled = div_round(raw * Q_ONE, osr_divisor(press_code));
			t = stored_temp;
			a = c20 * Q_ONE + scaled * c30;
			a = c10 * Q_ONE + mul_q24(a, scaled);
			a = c00 * Q_ONE + mul_q24(a, scaled);
			b = c11 * Q_ONE + scaled * c21;
			b = c01 * Q_ONE + mul_q24(b, scaled);
			r.value = to_q16(a + mul_q24(b, t), 64'd100);
		end
		return r;
	endfunction

	function automatic logic [23:0] pick_raw();
		logic signed [15:0] near_zero;
		near_zero = $urandom;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return 24'h800000;
					1: return 24'h7FFFFF;
					2: return 24'h000000;
					3: return 24'hFFFFFF;
					default: return 24'h000001;
				endcase
			end
			1: return 24'(near_zero);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_sample(logic func, logic [23:0] raw);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= raw;
		s_tuser <= func;
		do @(posedge clk); while (!s_tready);
		expected_readings.push_back(compensate(func, raw));
	endtask

	task automatic settle_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_readings.size() != 0);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_COEF_LOW: coef_low = value;
			REG_COEF_MID: coef_mid = value;
			REG_COEF_HIGH: coef_high = value[15:0];
			REG_TEMP_OSR: temp_code = value[2:0];
			REG_PRESS_OSR: press_code = value[2:0];
			default: ;
		endcase
	endtask

	task automatic load_calibration(logic [63:0] low, logic [63:0] mid, logic [63:0] high,
			logic [63:0] t_osr, logic [63:0] p_osr);
		settle_idle();
		write_reg(REG_COEF_LOW, low);
		write_reg(REG_COEF_MID, mid);
		write_reg(REG_COEF_HIGH, high);
		write_reg(REG_TEMP_OSR, t_osr);
		write_reg(REG_PRESS_OSR, p_osr);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_pressure_before_temperature();
		load_calibration({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			64'd0, 64'd0);
		send_sample(FUNC_PRESS, 24'h7FFFFF);
		send_sample(FUNC_PRESS, 24'h800000);
		send_sample(FUNC_PRESS, 24'($urandom));
	endtask

	task automatic test_ignored_writes();
		settle_idle();
		for (int i = int'(REG_PRESS_OSR) + 1; i < 2 ** REG_IDX_W; i++)
			write_reg(REG_IDX_W'(i), {$urandom, $urandom});
		write_reg(REG_COEF_HIGH, {$urandom, $urandom});
		write_reg(REG_TEMP_OSR, {$urandom, $urandom});
		write_reg(REG_PRESS_OSR, {$urandom, $urandom});
		cfg_valid <= 1'b0;
		send_sample(FUNC_TEMP, 24'($urandom));
		send_sample(FUNC_PRESS, 24'($urandom));
	endtask

	task automatic test_coefficient_extremes();
		load_calibration(64'h7FF7_FF7F_FFF7_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF,
			64'd4, 64'd4);
		send_sample(FUNC_TEMP, 24'h7FFFFF);
		send_sample(FUNC_PRESS, 24'h7FFFFF);
		send_sample(FUNC_PRESS, 24'h800000);
		send_sample(FUNC_TEMP, 24'h800000);
		send_sample(FUNC_PRESS, 24'h7FFFFF);
		load_calibration(64'h8008_0080_0008_0000, 64'h8000_8000_8000_8000, 64'h8000,
			64'd4, 64'd3);
		send_sample(FUNC_TEMP, 24'h800000);
		send_sample(FUNC_PRESS, 24'h800000);
		send_sample(FUNC_PRESS, 24'h7FFFFF);
		send_sample(FUNC_TEMP, 24'h7FFFFF);
		// odd negative c0: halving truncates toward zero
		load_calibration(64'h8010_0000_0000_0000, 64'd0, 64'd0, 64'd7, 64'd7);
		send_sample(FUNC_TEMP, 24'h000000);
		send_sample(FUNC_TEMP, 24'hFFFFFF);
		send_sample(FUNC_PRESS, 24'h000001);
	endtask

	task automatic test_random_phases();
		logic [63:0] t_osr, p_osr;
		logic        func;
		for (int phase = 0; phase < PHASES; phase++) begin
			src_quiet = (phase % 4 == 1);
			sink_quiet = (phase % 4 == 2);
			t_osr = {$urandom, $urandom};
			p_osr = {$urandom, $urandom};
			t_osr[2:0] = 3'(phase);
			p_osr[2:0] = 3'(7 - phase);
			if (phase % 5 == 0)
				load_calibration('1, '1, '1, t_osr, p_osr);
			else
				load_calibration({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, t_osr, p_osr);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				func = ($urandom_range(0, 99) < 35) ? FUNC_TEMP : FUNC_PRESS;
				send_sample(func, pick_raw());
			end
		end
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
	endtask

	initial begin : result_sink
		int stall;
		forever begin
			stall = sink_quiet ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : result_check
		reading_t due;
		if (m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				$error("unexpected result beat: quantity %0d compensated_value %0d",
					m_tuser, $signed(m_tdata));
				mismatch_count++;
			end else begin
				due = expected_readings.pop_front();
				if (m_tuser[0] !== due.quantity) begin
					$error("quantity: expected %0d, got %0d", due.quantity, m_tuser);
					mismatch_count++;
				end
				if (m_tdata !== due.value) begin
					$error("compensated_value: expected %0d, got %0d",
						$signed(due.value), $signed(m_tdata));
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		coef_low = '0;
		coef_mid = '0;
		coef_high = '0;
		temp_code = 3'd3;
		press_code = 3'd3;
		stored_temp = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pressure_before_temperature();
		test_ignored_writes();
		test_coefficient_extremes();
		test_random_phases();
		settle_idle();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
rtl/ptc_pkg.sv
rtl/ptc_div.sv
rtl/ptc_ctrl.sv
rtl/ptc_datapath.sv
rtl/pressure_temperature_compensation.sv
tb/tb_top.sv
